// ===== sv/rwvm_pkg.sv =====
// Package for the recency-weighted vector memory.
// Holds payload structs, opcodes, controller states and fixed widths.
package rwvm_pkg;

  localparam int unsigned QOne = 16384;

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_SUMMARY = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [0:0] {
    KIND_SUMMARY = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

  typedef enum logic [0:0] {
    REG_VECTOR_LENGTH  = 1'b0,
    REG_STORE_CAPACITY = 1'b1
  } reg_index_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] element_value;
    logic signed [15:0] strength_value;
    logic               final_element;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [15:0] summary_value;
    logic               append_status;
    logic               last_result;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOT,     // sum weights over stored vectors
    ST_TOTW,    // drain last weight product
    ST_DIM,     // start of one dimension
    ST_ACC,     // multiply-accumulate over stored vectors
    ST_ACCW,    // drain pipeline
    ST_DIV,     // restoring division
    ST_EMIT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic take;       // latch input item
    logic tot_clr;
    logic tot_step;   // advance over stored vectors for total
    logic acc_clr;
    logic acc_step;   // advance over stored vectors for dimension
    logic div_start;
    logic div_step;
    logic emit_sum;
    logic dim_next;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic walk_done;  // index reached stored count
    logic div_done;
    logic dim_last;
    logic tot_zero;
  } stat_t;

endpackage

// ===== sv/rwvm_ctrl.sv =====
// Controller state machine for the recency-weighted vector memory.
// Depends on rwvm_pkg; drives cmd_t into rwvm_dp and reads stat_t.
module rwvm_ctrl import rwvm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  in_item_t in_i,
  input  stat_t    stat_i,
  output logic     busy_o,
  output cmd_t     cmd_o
);

  state_e state_q, state_d;
  logic   pipe_q, pipe_d;  // drain flag, set once a drain state has been entered

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pipe_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pipe_q  <= pipe_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    pipe_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i && in_i.opcode == OP_SUMMARY) state_d = ST_TOT;
      end
      ST_TOT:  if (stat_i.walk_done) state_d = ST_TOTW;
      ST_TOTW: begin
        pipe_d = 1'b1;
        if (pipe_q) state_d = ST_DIM;
      end
      ST_DIM:  state_d = stat_i.tot_zero ? ST_EMIT : ST_ACC;
      ST_ACC:  if (stat_i.walk_done) state_d = ST_ACCW;
      ST_ACCW: begin
        pipe_d = 1'b1;
        if (pipe_q) state_d = ST_DIV;
      end
      ST_DIV:  if (stat_i.div_done) state_d = ST_EMIT;
      ST_EMIT: state_d = stat_i.dim_last ? ST_IDLE : ST_DIM;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    busy_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        cmd_o.take    = start_i;
        cmd_o.tot_clr = 1'b1;
      end
      ST_TOT:  cmd_o.tot_step = !stat_i.walk_done;
      ST_DIM:  cmd_o.acc_clr = 1'b1;
      ST_ACC:  cmd_o.acc_step = !stat_i.walk_done;
      ST_ACCW: cmd_o.div_start = pipe_q;
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_EMIT: begin
        cmd_o.emit_sum = 1'b1;
        cmd_o.dim_next = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== sv/rwvm_dp.sv =====
// Datapath: staging buffer, vector and strength memories, FIFO pointers,
// weighted sums and the serial divider. Depends on rwvm_pkg.
module rwvm_dp import rwvm_pkg::*; #(
  parameter int unsigned MaxLength  = 64,
  parameter int unsigned MaxVectors = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_index_i,
  input  logic [6:0] cfg_data_i,
  input  in_item_t   in_i,
  input  cmd_t       cmd_i,
  output stat_t      stat_o,
  output logic       strobe_o,
  output out_item_t  out_o
);

  localparam int unsigned LW  = (MaxLength > 1) ? $clog2(MaxLength) : 1;
  localparam int unsigned VW  = (MaxVectors > 1) ? $clog2(MaxVectors) : 1;
  localparam int unsigned CW  = $clog2(MaxVectors + 1);
  localparam int unsigned ICW = $clog2(MaxLength + 2);
  localparam int unsigned WW  = 15 + CW + 1;          // strength * weight
  localparam int unsigned TW  = WW + CW;              // total of weights
  localparam int unsigned AW  = TW + 16;              // signed accumulator
  localparam int unsigned DEPTH = MaxVectors * MaxLength;
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned QW  = 15;                   // quotient bits
  localparam logic [ICW-1:0] MaxLenC = ICW'(MaxLength);

  // configuration in use
  logic [6:0] len_reg_q;
  logic [5:0] cap_reg_q;
  logic [6:0] len_use;
  logic [CW-1:0] cap_use;
  logic       cfg_hit;
  always_comb begin
    if (len_reg_q == 7'd0) len_use = 7'd1;
    else if (32'(len_reg_q) > MaxLength) len_use = 7'(MaxLength);
    else len_use = len_reg_q;
    if (cap_reg_q == 6'd0) cap_use = CW'(1);
    else if (32'(cap_reg_q) > MaxVectors) cap_use = CW'(MaxVectors);
    else cap_use = CW'(cap_reg_q);
  end
  // of the configuration writes, only one to a known register empties the store
  assign cfg_hit = cfg_we_i &&
                   (cfg_index_i inside {7'(REG_VECTOR_LENGTH), 7'(REG_STORE_CAPACITY)});

  // FIFO state
  logic [VW-1:0]  oldest_q;
  logic [CW-1:0]  count_q;
  logic [ICW-1:0] incnt_q;
  logic           strobe_q;
  out_item_t      out_q;

  // staging buffer of the vector being appended, stored vectors and strengths
  logic signed [15:0] stage_mem [MaxLength];
  logic signed [15:0] vec_mem   [DEPTH];
  logic [14:0]        str_mem   [MaxVectors];

  // clamps on the incoming item
  logic signed [15:0] elem_c;
  logic [14:0]        str_c;
  always_comb begin
    if (in_i.element_value > 16'sd16384) elem_c = 16'sd16384;
    else if (in_i.element_value < -16'sd16384) elem_c = -16'sd16384;
    else elem_c = in_i.element_value;
    if (in_i.strength_value < 0) str_c = '0;
    else if (in_i.strength_value > 16'sd16384) str_c = 15'd16384;
    else str_c = in_i.strength_value[14:0];
  end

  logic is_app, is_fin, len_ok, full;
  logic [ICW-1:0] incnt_n;
  logic [VW-1:0] wr_slot, old_n;
  logic [CW:0]   sum_slot;
  assign is_app  = cmd_i.take && in_i.opcode == OP_APPEND;
  assign incnt_n = (incnt_q <= MaxLenC) ? incnt_q + ICW'(1) : incnt_q;
  assign is_fin  = is_app && in_i.final_element;
  assign len_ok  = (incnt_n == ICW'(len_use));
  assign full    = (count_q >= cap_use);
  always_comb begin
    sum_slot = (CW+1)'(oldest_q) + (full ? '0 : (CW+1)'(count_q));
    if (sum_slot >= (CW+1)'(cap_use)) sum_slot = sum_slot - (CW+1)'(cap_use);
    wr_slot = sum_slot[VW-1:0];
    old_n = (32'(oldest_q) + 1 >= 32'(cap_use)) ? '0 : oldest_q + VW'(1);
  end

  // copy sweep from staging buffer into the chosen slot
  logic          cp_act_q;
  logic [LW:0]   cp_idx_q;
  logic [VW-1:0] cp_slot_q;
  logic signed [15:0] stage_rd;
  logic [AddrW-1:0]   wr_addr;

  always_ff @(posedge clk_i) begin
    if (is_app && incnt_q < MaxLenC) stage_mem[incnt_q[LW-1:0]] <= elem_c;
    stage_rd <= stage_mem[cp_idx_q[LW-1:0]];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_reg_q <= 7'd64;
      cap_reg_q <= 6'd32;
      oldest_q  <= '0;
      count_q   <= '0;
      incnt_q   <= '0;
      cp_act_q  <= 1'b0;
      cp_idx_q  <= '0;
      cp_slot_q <= '0;
    end else begin
      if (cfg_we_i && cfg_index_i == 7'(REG_VECTOR_LENGTH)) len_reg_q <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == 7'(REG_STORE_CAPACITY)) cap_reg_q <= cfg_data_i[5:0];
      if (cfg_hit || (cmd_i.take && in_i.opcode == OP_CLEAR)) begin
        oldest_q <= '0;
        count_q  <= '0;
        incnt_q  <= '0;
      end else if (is_app) begin
        if (!in_i.final_element) incnt_q <= incnt_n;
        else begin
          incnt_q <= '0;
          if (len_ok) begin
            if (full) begin
              oldest_q <= old_n;
              count_q  <= cap_use;
            end else count_q <= count_q + CW'(1);
            cp_act_q  <= 1'b1;
            cp_idx_q  <= '0;
            cp_slot_q <= wr_slot;
          end
        end
      end
      // copy runs one element per cycle; the write takes the registered read, one index behind
      if (cp_act_q) begin
        cp_idx_q <= cp_idx_q + (LW+1)'(1);
        if (cp_idx_q == (LW+1)'(len_use)) cp_act_q <= 1'b0;
      end
    end
  end

  // stored strength and the delayed copy write
  assign wr_addr = AddrW'(cp_slot_q * MaxLength + cp_idx_q - 1);
  always_ff @(posedge clk_i) begin
    if (is_fin && len_ok) str_mem[wr_slot] <= str_c;
    if (cp_act_q && cp_idx_q != '0) vec_mem[wr_addr] <= stage_rd;
  end

  // walk over stored vectors
  logic [CW-1:0]  wi_q;
  logic [VW-1:0]  wslot_q;
  logic [LW-1:0]  dim_q;
  logic [CW-1:0]  den;
  assign den = (count_q > CW'(1)) ? count_q - CW'(1) : CW'(1);
  assign stat_o.walk_done = (wi_q == count_q);
  assign stat_o.dim_last  = (7'(dim_q) + 7'd1 == len_use);

  logic [14:0]        str_rd;
  logic signed [15:0] vec_rd;
  logic [CW:0]        wfac_q;
  logic               v1_q, v2_q;
  logic [WW-1:0]      w_q;
  logic [TW-1:0]      tot_q;
  logic signed [AW-1:0] acc_q;
  logic               in_acc_q;
  logic [AddrW-1:0]   rd_addr;

  // stage 1: memory reads and recency factor
  assign rd_addr = AddrW'(wslot_q * MaxLength + dim_q);
  always_ff @(posedge clk_i) begin
    str_rd <= str_mem[wslot_q];
    vec_rd <= vec_mem[rd_addr];
    wfac_q <= (CW+1)'(den) + (CW+1)'(wi_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q <= '0; wslot_q <= '0; dim_q <= '0;
      v1_q <= 1'b0; v2_q <= 1'b0; in_acc_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.tot_step || cmd_i.acc_step;
      v2_q <= v1_q;
      if (cmd_i.tot_clr || cmd_i.acc_clr) begin
        wi_q <= '0;
        wslot_q <= oldest_q;
        in_acc_q <= cmd_i.acc_clr;
      end else if (cmd_i.tot_step || cmd_i.acc_step) begin
        wi_q <= wi_q + CW'(1);
        wslot_q <= (32'(wslot_q) + 1 >= 32'(cap_use)) ? '0 : wslot_q + VW'(1);
      end
      if (cmd_i.take) dim_q <= '0;
      else if (cmd_i.dim_next) dim_q <= dim_q + LW'(1);
    end
  end

  // stage 2: weight product; stage 3: accumulate
  logic signed [15:0] vec_d2;
  logic signed [AW-1:0] prod;
  always_ff @(posedge clk_i) begin
    w_q    <= WW'(str_rd) * WW'(wfac_q);
    vec_d2 <= vec_rd;
    if (cmd_i.tot_clr) tot_q <= '0;
    else if (v2_q && !in_acc_q) tot_q <= tot_q + TW'(w_q);
    if (cmd_i.acc_clr) acc_q <= '0;
    else if (v2_q && in_acc_q) acc_q <= acc_q + prod;
  end
  assign prod = AW'(vec_d2) * AW'($signed({1'b0, w_q}));
  assign stat_o.tot_zero = (tot_q == '0);

  // restoring divider, one quotient bit a cycle; quotient saturates at QOne
  logic [AW-1:0] mag_q;
  logic [TW:0]   rem_q;
  logic [QW:0]   quo_q;
  logic [5:0]    dcnt_q;
  logic          neg_q;
  logic [TW:0]   rem_try;
  logic [AW:0]   mag2;
  assign mag2 = {1'b0, (acc_q < 0) ? AW'(-acc_q) : AW'(acc_q)} + (AW+1)'(tot_q >> 1);
  assign rem_try = {rem_q[TW-1:0], mag_q[AW-1]};
  assign stat_o.div_done = (dcnt_q == '0);
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      mag_q  <= mag2[AW-1:0];
      rem_q  <= '0;
      quo_q  <= '0;
      dcnt_q <= 6'(AW);
      neg_q  <= acc_q < 0;
    end else if (cmd_i.div_step && dcnt_q != '0) begin
      mag_q  <= mag_q << 1;
      dcnt_q <= dcnt_q - 6'd1;
      if (rem_try >= (TW+1)'(tot_q)) begin
        rem_q <= rem_try - (TW+1)'(tot_q);
        quo_q <= (quo_q > (QW+1)'(QOne)) ? quo_q : {quo_q[QW-1:0], 1'b1};
      end else begin
        rem_q <= rem_try;
        quo_q <= (quo_q > (QW+1)'(QOne)) ? quo_q : {quo_q[QW-1:0], 1'b0};
      end
    end
  end

  // result register
  logic [15:0] qsat;
  assign qsat = (quo_q > (QW+1)'(QOne)) ? 16'(QOne) : 16'(quo_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) strobe_q <= 1'b0;
    else strobe_q <= is_fin || cmd_i.emit_sum;
  end
  always_ff @(posedge clk_i) begin
    if (is_fin) begin
      out_q.result_kind   <= KIND_STATUS;
      out_q.summary_value <= '0;
      out_q.append_status <= !len_ok;
      out_q.last_result   <= 1'b1;
    end else begin
      out_q.result_kind   <= KIND_SUMMARY;
      out_q.summary_value <= tot_q == '0 ? '0 : (neg_q ? -$signed(qsat) : $signed(qsat));
      out_q.append_status <= 1'b0;
      out_q.last_result   <= stat_o.dim_last;
    end
  end
  assign strobe_o = strobe_q;
  assign out_o    = out_q;

endmodule

// ===== sv/recency_weighted_vector_memory.sv =====
// Recency-weighted vector memory, top level; depends on rwvm_pkg, rwvm_ctrl, rwvm_dp.
// Append: one element per cycle while busy is low; the final element returns its
// status beat in the next cycle and holds busy while the vector is copied in.
// Summary over n stored vectors: a walk that totals the weights, then per dimension
// an accumulate walk, a division and a result beat (no walk or division when the
// total weight is zero). The receiver cannot stall. Reset empties the store at once.
module recency_weighted_vector_memory import rwvm_pkg::*; #(
  parameter int unsigned MaxLength  = 64,
  parameter int unsigned MaxVectors = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item_i,
  output logic       done_o,
  output out_item_t  out_item_o,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_index_i,
  input  logic [6:0] cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;
  logic  ctl_busy, cp_busy_q, cp_busy_d;
  logic [7:0] cp_cnt_q;

  // hold off new items while a copy sweep runs
  assign cp_busy_d = start && !busy && in_item_i.opcode == OP_APPEND
                     && in_item_i.final_element;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_busy_q <= 1'b0;
      cp_cnt_q  <= '0;
    end else if (cp_busy_d) begin
      cp_busy_q <= 1'b1;
      cp_cnt_q  <= 8'(MaxLength + 2);
    end else if (cp_cnt_q != '0) begin
      cp_cnt_q <= cp_cnt_q - 8'd1;
      if (cp_cnt_q == 8'd1) cp_busy_q <= 1'b0;
    end
  end
  assign busy = ctl_busy || cp_busy_q;

  rwvm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i (start && !busy),
    .in_i    (in_item_i),
    .stat_i  (stat),
    .busy_o  (ctl_busy),
    .cmd_o   (cmd)
  );

  rwvm_dp #(.MaxLength(MaxLength), .MaxVectors(MaxVectors)) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_i     (in_item_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .strobe_o (done_o),
    .out_o    (out_item_o)
  );

endmodule

// ===== sv/rwvm_checker.sv =====
// Port-level assertions for the recency-weighted vector memory.
// Depends on rwvm_pkg; bound to the top level.
module rwvm_port_props import rwvm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input logic      done_o,
  input in_item_t  in_item_i,
  input out_item_t out_item_o
);

  // a status beat follows an accepted final append element
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && in_item_i.opcode == OP_APPEND && in_item_i.final_element
    |=> done_o && out_item_o.result_kind == KIND_STATUS)
    else $error("missing status beat");

  // status beats always close their run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_item_o.result_kind == KIND_STATUS |-> out_item_o.last_result)
    else $error("status without last");

  // summary values stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_item_o.result_kind == KIND_SUMMARY |->
    out_item_o.summary_value <= 16'sd16384 && out_item_o.summary_value >= -16'sd16384)
    else $error("summary out of range");

  // accepted summary makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && in_item_i.opcode == OP_SUMMARY |=> busy)
    else $error("summary not busy");

endmodule

bind recency_weighted_vector_memory rwvm_port_props u_chk (.*);
